// ----- rtl/text_console_writer_unit_macros.svh -----
// Assertion helpers for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_WRITER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw check failed");
// Next-cycle implication.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw check failed");
`else
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons)
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

  localparam int SCREEN_ROWS_DEF = 25;
  localparam int MAX_COLUMNS_DEF = 80;
  localparam int PAGE_COUNT_DEF  = 8;

  localparam int COL_W    = 7;
  localparam int LINE_W   = 5;
  localparam int CODE_W   = 8;
  localparam int IDX_W    = 11;
  localparam int CELL_W   = 16;
  localparam int PAGE_W   = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [LINE_W-1:0] line_t;
  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [PAGE_W-1:0] page_t;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PAGE = 1'b1;
  localparam col_t COLUMNS_RESET = 7'd80;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0]        PRINT_ATTR   = 8'h04;
  localparam cell_t             BLANK_CELL   = 16'h0400;
  localparam cell_t             CLEAR_CELL   = 16'h0000;

  typedef struct packed {
    logic              kind;
    logic [CODE_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } in_item_t;

  typedef struct packed {
    cell_t cell_data;
    col_t  cursor_column;
    line_t cursor_line;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT,
    ST_COPY,
    ST_FILL,
    ST_DONE
  } tcw_state_t;

endpackage

// ----- rtl/tcw_screen_ram.sv -----
module tcw_screen_ram #(
  parameter int DEPTH = tcw_pkg::SCREEN_ROWS_DEF * tcw_pkg::MAX_COLUMNS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  tcw_pkg::cell_t   wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output tcw_pkg::cell_t   rdata
);

  tcw_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tcw_cursor_file.sv -----
module tcw_cursor_file #(
  parameter int PAGE_COUNT  = tcw_pkg::PAGE_COUNT_DEF,
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
  parameter int PGW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1,
  parameter int LW  = $clog2(SCREEN_ROWS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PGW-1:0]       page,
  output tcw_pkg::col_t        col,
  output logic [LW-1:0]        row,
  input  logic                 we,
  input  tcw_pkg::col_t        wcol,
  input  logic [LW-1:0]        wrow
);

  tcw_pkg::col_t col_q [PAGE_COUNT];
  logic [LW-1:0] row_q [PAGE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PAGE_COUNT; i++) begin
        col_q[i] <= '0;
        row_q[i] <= '0;
      end
    end else if (we) begin
      col_q[page] <= wcol;
      row_q[page] <= wrow;
    end
  end

  assign col = col_q[page];
  assign row = row_q[page];

endmodule

// ----- rtl/tcw_ctrl.sv -----
`include "text_console_writer_unit_macros.svh"

module tcw_ctrl #(
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
  parameter int MAX_COLUMNS = tcw_pkg::MAX_COLUMNS_DEF,
  parameter int DEPTH = SCREEN_ROWS * MAX_COLUMNS,
  parameter int AW    = $clog2(DEPTH),
  parameter int PW    = $clog2(DEPTH + 1),
  parameter int LW    = $clog2(SCREEN_ROWS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcw_pkg::in_item_t   in_data,
  input  tcw_pkg::col_t       cols,
  input  logic                out_free,
  output logic                res_valid,
  output tcw_pkg::out_item_t  res,
  input  tcw_pkg::col_t       cur_col,
  input  logic [LW-1:0]       cur_row,
  output logic                cur_we,
  output tcw_pkg::col_t       cur_wcol,
  output logic [LW-1:0]       cur_wrow,
  output logic                mem_we,
  output logic [AW-1:0]       mem_waddr,
  output tcw_pkg::cell_t      mem_wdata,
  output logic                mem_re,
  output logic [AW-1:0]       mem_raddr,
  input  tcw_pkg::cell_t      mem_rdata
);

  tcw_pkg::tcw_state_t state, state_next;
  logic [PW-1:0]       ptr, ptr_next;
  logic                cp_valid, cp_valid_next;
  logic [AW-1:0]       cp_addr, cp_addr_next;
  tcw_pkg::in_item_t   item;
  logic                in_range;
  logic                accept;

  logic [PW-1:0]       lim;
  tcw_pkg::col_t       col_w, col_inc;
  logic                is_nl, wrap, scroll;
  logic [LW:0]         row_adv;
  logic [PW-1:0]       put_addr;

  assign in_stall = (state != tcw_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign lim      = PW'(cols) * PW'(SCREEN_ROWS);

  // put arithmetic
  always_comb begin
    col_w   = (cur_col >= cols) ? cols - 7'd1 : cur_col;
    col_inc = col_w + 7'd1;
    is_nl   = (item.char_code == tcw_pkg::NEWLINE_CODE);
    wrap    = is_nl || (col_inc >= cols);
    row_adv = wrap ? {1'b0, cur_row} + (LW+1)'(1) : {1'b0, cur_row};
    scroll  = (int'(row_adv) >= SCREEN_ROWS);
    put_addr = PW'(cols) * PW'(cur_row) + PW'(col_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tcw_pkg::ST_CLEAR;
      ptr      <= '0;
      cp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      ptr      <= ptr_next;
      cp_valid <= cp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr <= cp_addr_next;
    if (accept) begin
      item     <= in_data;
      in_range <= (int'(in_data.cell_index) < DEPTH);
    end
  end

  always_comb begin
    state_next    = state;
    ptr_next      = ptr;
    cp_valid_next = 1'b0;
    cp_addr_next  = cp_addr;
    mem_we    = 1'b0;
    mem_waddr = AW'(ptr);
    mem_wdata = tcw_pkg::CLEAR_CELL;
    mem_re    = 1'b0;
    mem_raddr = AW'(ptr);
    cur_we    = 1'b0;
    cur_wcol  = wrap ? '0 : col_inc;
    cur_wrow  = scroll ? LW'(SCREEN_ROWS - 1) : row_adv[LW-1:0];
    res_valid = 1'b0;
    res.cell_data     = (item.kind == tcw_pkg::KIND_READ && in_range) ? mem_rdata : '0;
    res.cursor_column = cur_col;
    res.cursor_line   = tcw_pkg::line_t'(cur_row);

    case (state)
      tcw_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        ptr_next = ptr + PW'(1);
        if (ptr == PW'(DEPTH - 1)) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          mem_re    = (in_data.kind == tcw_pkg::KIND_READ);
          mem_raddr = AW'(in_data.cell_index);
          state_next = (in_data.kind == tcw_pkg::KIND_READ) ?
                       tcw_pkg::ST_DONE : tcw_pkg::ST_PUT;
        end
      end
      tcw_pkg::ST_PUT: begin
        mem_we    = !is_nl;
        mem_waddr = AW'(put_addr);
        mem_wdata = {tcw_pkg::PRINT_ATTR, item.char_code};
        cur_we    = 1'b1;
        if (scroll) begin
          ptr_next   = PW'(cols);
          state_next = tcw_pkg::ST_COPY;
        end else begin
          state_next = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_COPY: begin
        // read row r, write the word back one row up in the following cycle
        mem_we    = cp_valid;
        mem_waddr = cp_addr;
        mem_wdata = mem_rdata;
        if (ptr < lim) begin
          mem_re        = 1'b1;
          cp_valid_next = 1'b1;
          cp_addr_next  = AW'(ptr - PW'(cols));
          ptr_next      = ptr + PW'(1);
        end else begin
          ptr_next   = lim - PW'(cols);
          state_next = tcw_pkg::ST_FILL;
        end
      end
      tcw_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::BLANK_CELL;
        ptr_next  = ptr + PW'(1);
        if (ptr == lim - PW'(1)) begin
          state_next = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (out_free) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  `TCW_ASSERT_NOW(a_waddr_range, clk, rst, mem_we, int'(mem_waddr) < DEPTH)
  `TCW_ASSERT_NOW(a_row_range, clk, rst, state != tcw_pkg::ST_CLEAR, int'(cur_row) < SCREEN_ROWS)
  `TCW_ASSERT_NOW(a_copy_lag, clk, rst, state == tcw_pkg::ST_COPY && mem_we, (PW'(mem_waddr) + PW'(cols)) == $past(ptr))
  `TCW_ASSERT_NEXT(a_done_idle, clk, rst, state == tcw_pkg::ST_DONE && out_free, state == tcw_pkg::ST_IDLE)

endmodule

// ----- rtl/text_console_writer_unit.sv -----
// Text console writer: teletype output into a cell store with per-page cursors.
// A read passes ST_DONE into the output register; a put passes ST_PUT, then ST_DONE.
// One item at a time: input stalls until the output register takes the result.
// A scrolling put copies rows 1 to SCREEN_ROWS-1 up one row, then blanks the last row.
// Reset (rst, synchronous): registers to defaults, then a clearing pass zeroes all
// SCREEN_ROWS*MAX_COLUMNS cells (2000 by default) of the store before input opens.
module text_console_writer_unit #(
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
  parameter int MAX_COLUMNS = tcw_pkg::MAX_COLUMNS_DEF,
  parameter int PAGE_COUNT  = tcw_pkg::PAGE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  tcw_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output tcw_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DEPTH = SCREEN_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int LW    = $clog2(SCREEN_ROWS);
  localparam int PGW   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  // configuration registers
  tcw_pkg::col_t  columns;
  tcw_pkg::page_t active_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns     <= tcw_pkg::COLUMNS_RESET;
      active_page <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_COLUMNS:     columns     <= tcw_pkg::col_t'(cfg_data);
        tcw_pkg::CFG_ACTIVE_PAGE: active_page <= tcw_pkg::page_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // Effective column count: zero acts as one, anything above MAX_COLUMNS
  // saturates at MAX_COLUMNS.
  tcw_pkg::col_t  cols;
  logic [PGW-1:0] page_sel;

  always_comb begin
    if (columns == '0) begin
      cols = tcw_pkg::col_t'(1);
    end else if (int'(columns) > MAX_COLUMNS) begin
      cols = tcw_pkg::col_t'(MAX_COLUMNS);
    end else begin
      cols = columns;
    end
    // out-of-range page picks the top page
    if (int'(active_page) >= PAGE_COUNT) begin
      page_sel = PGW'(PAGE_COUNT - 1);
    end else begin
      page_sel = PGW'(active_page);
    end
  end

  // cursor file
  tcw_pkg::col_t  cur_col, cur_wcol;
  logic [LW-1:0]  cur_row, cur_wrow;
  logic           cur_we;

  tcw_cursor_file #(
    .PAGE_COUNT (PAGE_COUNT),
    .SCREEN_ROWS(SCREEN_ROWS),
    .PGW        (PGW),
    .LW         (LW)
  ) u_cursor (
    .clk (clk),
    .rst (rst),
    .page(page_sel),
    .col (cur_col),
    .row (cur_row),
    .we  (cur_we),
    .wcol(cur_wcol),
    .wrow(cur_wrow)
  );

  // screen store: one write port, one registered read port
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  tcw_pkg::cell_t  mem_wdata, mem_rdata;

  tcw_screen_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // sequencer: clear pass, put, scroll copy/fill, read
  logic               res_valid, out_free;
  tcw_pkg::out_item_t res;

  tcw_ctrl #(
    .SCREEN_ROWS(SCREEN_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS),
    .DEPTH      (DEPTH),
    .AW         (AW),
    .PW         (PW),
    .LW         (LW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cols     (cols),
    .out_free (out_free),
    .res_valid(res_valid),
    .res      (res),
    .cur_col  (cur_col),
    .cur_row  (cur_row),
    .cur_we   (cur_we),
    .cur_wcol (cur_wcol),
    .cur_wrow (cur_wrow),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // Output register: holds a finished result while the next item is taken.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_data <= res;
    end
  end

endmodule
